### rtl/sfr_pkg.sv
// Shared types and constants for the serial frame receiver.
// Used by sfr_core and serial_frame_receiver; no dependencies.

package sfr_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 16;
	localparam int unsigned INDEX_W  = 10;
	localparam int unsigned STATUS_W = 3;

	// payload bytes at positions below this are carried out
	localparam logic [LEN_W:0] PAYLOAD_CAPACITY = 17'd1024;

	localparam logic [BYTE_W-1:0] SOH_BYTE = 8'h01;

	typedef enum logic [0:0] {
		REQ_BYTE  = 1'b0,
		REQ_REARM = 1'b1
	} req_type_t;

	typedef enum logic [3:0] {
		PH_SOH  = 4'd0,
		PH_CMD  = 4'd1,
		PH_SUB  = 4'd2,
		PH_L1   = 4'd3,
		PH_L2   = 4'd4,
		PH_DATA = 4'd5,
		PH_CS0  = 4'd6,
		PH_CS1  = 4'd7,
		PH_DONE = 4'd8
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_IGNORED = 3'd0,
		ST_HEADER  = 3'd1,
		ST_PAYLOAD = 3'd2,
		ST_SUMLOW  = 3'd3,
		ST_GOOD    = 3'd4,
		ST_BAD     = 3'd5,
		ST_REARMED = 3'd6
	} status_t;

	typedef struct packed {
		status_t             status;
		logic                payload_valid;
		logic [BYTE_W-1:0]   payload_byte;
		logic [INDEX_W-1:0]  payload_index;
		logic [BYTE_W-1:0]   command_code;
		logic [BYTE_W-1:0]   subcommand_code;
		logic [LEN_W-1:0]    payload_length;
		logic                oversize;
	} result_t;

endpackage

### rtl/sfr_core.sv
// Frame parse state and per-byte next-state logic of the serial frame receiver.
// Depends on sfr_pkg. Produces the result for the byte accepted this cycle.

module sfr_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic                        req_type,
	input  logic [sfr_pkg::BYTE_W-1:0]  rx_byte,
	output sfr_pkg::result_t            res
);

	sfr_pkg::phase_t              phase_q, phase_d;
	logic [sfr_pkg::LEN_W-1:0]    running_sum_q, running_sum_d;
	logic [sfr_pkg::LEN_W-1:0]    received_sum_q, received_sum_d;
	logic [sfr_pkg::BYTE_W-1:0]   command_q, command_d;
	logic [sfr_pkg::BYTE_W-1:0]   subcommand_q, subcommand_d;
	logic [sfr_pkg::LEN_W-1:0]    length_q, length_d;
	logic [sfr_pkg::LEN_W-1:0]    byte_count_q, byte_count_d;
	logic                         oversize_q, oversize_d;

	logic [sfr_pkg::LEN_W-1:0]    sum_add;
	logic [sfr_pkg::LEN_W-1:0]    len_full;
	logic [sfr_pkg::LEN_W-1:0]    rsum_full;
	logic [sfr_pkg::LEN_W-1:0]    count_inc;
	logic                         below_cap;
	sfr_pkg::status_t             status;
	logic                         pvalid;

	assign sum_add   = running_sum_q + {{(sfr_pkg::LEN_W-sfr_pkg::BYTE_W){1'b0}}, rx_byte};
	assign len_full  = {rx_byte, length_q[sfr_pkg::BYTE_W-1:0]};
	assign rsum_full = {rx_byte, received_sum_q[sfr_pkg::BYTE_W-1:0]};
	assign count_inc = byte_count_q + 16'd1;
	assign below_cap = {1'b0, byte_count_q} < sfr_pkg::PAYLOAD_CAPACITY;

	always_comb begin
		phase_d        = phase_q;
		running_sum_d  = running_sum_q;
		received_sum_d = received_sum_q;
		command_d      = command_q;
		subcommand_d   = subcommand_q;
		length_d       = length_q;
		byte_count_d   = byte_count_q;
		oversize_d     = oversize_q;
		status         = sfr_pkg::ST_IGNORED;
		pvalid         = 1'b0;

		if (req_type == sfr_pkg::REQ_REARM) begin
			phase_d       = sfr_pkg::PH_SOH;
			running_sum_d = '0;
			status        = sfr_pkg::ST_REARMED;
		end else begin
			unique case (phase_q)
				sfr_pkg::PH_SOH: begin
					running_sum_d = '0;
					if (rx_byte == sfr_pkg::SOH_BYTE) begin
						running_sum_d = {{(sfr_pkg::LEN_W-sfr_pkg::BYTE_W){1'b0}}, rx_byte};
						command_d     = '0;
						subcommand_d  = '0;
						length_d      = '0;
						byte_count_d  = '0;
						oversize_d    = 1'b0;
						phase_d       = sfr_pkg::PH_CMD;
						status        = sfr_pkg::ST_HEADER;
					end
				end
				sfr_pkg::PH_CMD: begin
					running_sum_d = sum_add;
					command_d     = rx_byte;
					phase_d       = sfr_pkg::PH_SUB;
					status        = sfr_pkg::ST_HEADER;
				end
				sfr_pkg::PH_SUB: begin
					running_sum_d = sum_add;
					subcommand_d  = rx_byte;
					phase_d       = sfr_pkg::PH_L1;
					status        = sfr_pkg::ST_HEADER;
				end
				sfr_pkg::PH_L1: begin
					running_sum_d = sum_add;
					length_d      = {{(sfr_pkg::LEN_W-sfr_pkg::BYTE_W){1'b0}}, rx_byte};
					phase_d       = sfr_pkg::PH_L2;
					status        = sfr_pkg::ST_HEADER;
				end
				sfr_pkg::PH_L2: begin
					running_sum_d = sum_add;
					length_d      = len_full;
					byte_count_d  = '0;
					oversize_d    = {1'b0, len_full} > sfr_pkg::PAYLOAD_CAPACITY;
					// empty payload goes straight to the sum bytes
					phase_d       = (len_full != '0) ? sfr_pkg::PH_DATA : sfr_pkg::PH_CS0;
					status        = sfr_pkg::ST_HEADER;
				end
				sfr_pkg::PH_DATA: begin
					running_sum_d = sum_add;
					pvalid        = below_cap;
					byte_count_d  = count_inc;
					if (count_inc == length_q) begin
						phase_d = sfr_pkg::PH_CS0;
					end
					status        = sfr_pkg::ST_PAYLOAD;
				end
				sfr_pkg::PH_CS0: begin
					received_sum_d = {{(sfr_pkg::LEN_W-sfr_pkg::BYTE_W){1'b0}}, rx_byte};
					phase_d        = sfr_pkg::PH_CS1;
					status         = sfr_pkg::ST_SUMLOW;
				end
				sfr_pkg::PH_CS1: begin
					received_sum_d = rsum_full;
					status  = (rsum_full == running_sum_q) ? sfr_pkg::ST_GOOD : sfr_pkg::ST_BAD;
					phase_d = sfr_pkg::PH_DONE;
				end
				default: begin
					status = sfr_pkg::ST_IGNORED;
				end
			endcase
		end
	end

	always_comb begin
		res.status          = status;
		res.payload_valid   = pvalid;
		res.payload_byte    = pvalid ? rx_byte : '0;
		res.payload_index   = pvalid ? byte_count_q[sfr_pkg::INDEX_W-1:0] : '0;
		res.command_code    = command_d;
		res.subcommand_code = subcommand_d;
		res.payload_length  = length_d;
		res.oversize        = oversize_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= sfr_pkg::PH_SOH;
			running_sum_q  <= '0;
			received_sum_q <= '0;
			command_q      <= '0;
			subcommand_q   <= '0;
			length_q       <= '0;
			byte_count_q   <= '0;
			oversize_q     <= 1'b0;
		end else if (accept) begin
			phase_q        <= phase_d;
			running_sum_q  <= running_sum_d;
			received_sum_q <= received_sum_d;
			command_q      <= command_d;
			subcommand_q   <= subcommand_d;
			length_q       <= length_d;
			byte_count_q   <= byte_count_d;
			oversize_q     <= oversize_d;
		end
	end

`ifndef SYNTHESIS
	a_rearm_to_soh: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == sfr_pkg::REQ_REARM) |=>
		(phase_q == sfr_pkg::PH_SOH && running_sum_q == '0))
		else $error("rearm did not return parser to start-byte wait");

	a_pvalid_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res.payload_valid) |->
		(res.status == sfr_pkg::ST_PAYLOAD && below_cap && phase_q == sfr_pkg::PH_DATA))
		else $error("payload carried out outside payload phase or capacity");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == sfr_pkg::REQ_BYTE && phase_q == sfr_pkg::PH_DONE) |=>
		(phase_q == sfr_pkg::PH_DONE && $stable(running_sum_q) && $stable(length_q)))
		else $error("finished frame changed state without rearm");

	a_sum_status: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (res.status == sfr_pkg::ST_GOOD || res.status == sfr_pkg::ST_BAD)) |=>
		(phase_q == sfr_pkg::PH_DONE))
		else $error("checksum verdict without entering done phase");
`endif

endmodule

### rtl/serial_frame_receiver.sv
// Serial frame receiver top level: stream handshake and result register.
// Depends on sfr_pkg and sfr_core.
//
// Usage:
//   Slave channel s_axis_*: one item per received byte (tuser = 0) or a
//   rearm request (tuser = 1). Master channel m_axis_*: exactly one result
//   item per accepted input item, in order.
//   The result for an item is presented in the cycle after it is accepted.
//   Throughput: one item per cycle while the result register is empty or
//   m_axis_tready is high; the parse state update is a single add and phase
//   step between the input handshake and the result register.
//   The result register decouples the sides: a new item is accepted while
//   the previous result is taken in the same cycle. If the result register is
//   full and m_axis_tready is low, s_axis_tready drops and the parse state
//   holds until the result is taken.
//   Reset: the parser waits for the start byte, all frame registers are zero
//   and the result register is empty.

module serial_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        s_axis_tuser,   // [0] req_type

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] payload_byte, [17:8] payload_index, [25:18] command_code,
	// [33:26] subcommand_code, [49:34] payload_length, [50] oversize, [55:51] zero
	output logic [55:0] m_axis_tdata,
	output logic [3:0]  m_axis_tuser    // [2:0] status, [3] payload_valid
);

	logic             in_accept;
	sfr_pkg::result_t res;
	sfr_pkg::result_t res_q;
	logic             out_valid_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	sfr_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (in_accept),
		.req_type (s_axis_tuser),
		.rx_byte  (s_axis_tdata),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = {res_q.payload_valid, res_q.status};
	assign m_axis_tdata  = {5'd0,
	                        res_q.oversize,
	                        res_q.payload_length,
	                        res_q.subcommand_code,
	                        res_q.command_code,
	                        res_q.payload_index,
	                        res_q.payload_byte};

endmodule

### dv/serial_frame_receiver_test.sv
// Self-checking bench for serial_frame_receiver: streams framed bytes and rearm
// requests, predicts every status item in a parser mirror and compares fields.
// Depends on sfr_pkg and the serial_frame_receiver RTL.

module serial_frame_receiver_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 4000;

	typedef struct {
		sfr_pkg::req_type_t req;
		logic [7:0]         data;
	} rx_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;

	serial_frame_receiver dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial forever #6 clk = ~clk;

	rx_item_t          rx_items_q[$];
	sfr_pkg::result_t  parse_results_q[$];
	rx_item_t          next_item;

	int queued_count = 0;
	int accepted_count = 0;
	int phase_items = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	bit rx_taken = 1'b0;
	bit in_acc, out_acc;

	// parser mirror
	sfr_pkg::phase_t frame_phase = sfr_pkg::PH_SOH;
	logic [15:0] frame_sum = '0;
	logic [15:0] rcvd_sum = '0;
	logic [7:0]  cmd_q = '0;
	logic [7:0]  sub_q = '0;
	logic [15:0] len_q = '0;
	logic [15:0] byte_count = '0;
	logic        oversize_q = 1'b0;

	function automatic sfr_pkg::result_t parse_rx_item(sfr_pkg::req_type_t req,
			logic [7:0] b);
		sfr_pkg::result_t r;
		r = '0;
		r.status = sfr_pkg::ST_IGNORED;
		if (req == sfr_pkg::REQ_REARM) begin
			frame_phase = sfr_pkg::PH_SOH;
			frame_sum = '0;
			r.status = sfr_pkg::ST_REARMED;
		end else begin
			case (frame_phase)
				sfr_pkg::PH_SOH: begin
					frame_sum = '0;
					if (b == sfr_pkg::SOH_BYTE) begin
						frame_sum = 16'(b);
						cmd_q = '0;
						sub_q = '0;
						len_q = '0;
						byte_count = '0;
						oversize_q = 1'b0;
						frame_phase = sfr_pkg::PH_CMD;
						r.status = sfr_pkg::ST_HEADER;
					end
				end
				sfr_pkg::PH_CMD: begin
					frame_sum = frame_sum + 16'(b);
					cmd_q = b;
					frame_phase = sfr_pkg::PH_SUB;
					r.status = sfr_pkg::ST_HEADER;
				end
				sfr_pkg::PH_SUB: begin
					frame_sum = frame_sum + 16'(b);
					sub_q = b;
					frame_phase = sfr_pkg::PH_L1;
					r.status = sfr_pkg::ST_HEADER;
				end
				sfr_pkg::PH_L1: begin
					frame_sum = frame_sum + 16'(b);
					len_q = 16'(b);
					frame_phase = sfr_pkg::PH_L2;
					r.status = sfr_pkg::ST_HEADER;
				end
				sfr_pkg::PH_L2: begin
					frame_sum = frame_sum + 16'(b);
					len_q = {b, len_q[7:0]};
					byte_count = '0;
					oversize_q = (17'(len_q) > sfr_pkg::PAYLOAD_CAPACITY);
					if (len_q != 16'd0)
						frame_phase = sfr_pkg::PH_DATA;
					else
						frame_phase = sfr_pkg::PH_CS0;
					r.status = sfr_pkg::ST_HEADER;
				end
				sfr_pkg::PH_DATA: begin
					frame_sum = frame_sum + 16'(b);
					if (17'(byte_count) < sfr_pkg::PAYLOAD_CAPACITY) begin
						r.payload_valid = 1'b1;
						r.payload_byte = b;
						r.payload_index = byte_count[sfr_pkg::INDEX_W-1:0];
					end
					byte_count = byte_count + 16'd1;
					if (byte_count == len_q)
						frame_phase = sfr_pkg::PH_CS0;
					r.status = sfr_pkg::ST_PAYLOAD;
				end
				sfr_pkg::PH_CS0: begin
					rcvd_sum = 16'(b);
					frame_phase = sfr_pkg::PH_CS1;
					r.status = sfr_pkg::ST_SUMLOW;
				end
				sfr_pkg::PH_CS1: begin
					rcvd_sum = {b, rcvd_sum[7:0]};
					r.status = (rcvd_sum == frame_sum) ? sfr_pkg::ST_GOOD : sfr_pkg::ST_BAD;
					frame_phase = sfr_pkg::PH_DONE;
				end
				default: r.status = sfr_pkg::ST_IGNORED;
			endcase
		end
		r.command_code = cmd_q;
		r.subcommand_code = sub_q;
		r.payload_length = len_q;
		r.oversize = oversize_q;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
		if (seen !== want) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, seen);
			mismatch_count++;
		end
	endfunction

	task automatic add_item(sfr_pkg::req_type_t req, logic [7:0] b);
		rx_items_q.push_back('{req: req, data: b});
		queued_count++;
		phase_items++;
	endtask

	// cut >= 0: send only the first cut bytes of the frame, then rearm
	task automatic add_frame(input logic [7:0] cmd, input logic [7:0] sub,
			input logic [15:0] len, input int cut, input bit corrupt, input int extras);
		logic [15:0] sum;
		logic [7:0]  b;
		int          stop;
		stop = (cut >= 0) ? cut : 7 + int'(len);
		sum = '0;
		for (int pos = 0; pos < stop; pos++) begin
			if (pos == 0)
				b = sfr_pkg::SOH_BYTE;
			else if (pos == 1)
				b = cmd;
			else if (pos == 2)
				b = sub;
			else if (pos == 3)
				b = len[7:0];
			else if (pos == 4)
				b = len[15:8];
			else if (pos < 5 + int'(len))
				b = 8'($urandom);
			else begin
				if (pos == 5 + int'(len) && corrupt)
					sum = sum ^ (16'd1 << $urandom_range(0, 15));
				b = (pos == 5 + int'(len)) ? sum[7:0] : sum[15:8];
			end
			if (pos < 5 + int'(len))
				sum = sum + 16'(b);
			add_item(sfr_pkg::REQ_BYTE, b);
		end
		if (cut < 0)
			repeat (extras) add_item(sfr_pkg::REQ_BYTE, 8'($urandom));
		add_item(sfr_pkg::REQ_REARM, 8'($urandom));
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || rx_taken) begin
			if (rx_items_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				next_item = rx_items_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= next_item.req;
				s_axis_tdata <= next_item.data;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		m_axis_tready <= arst_n && ($urandom_range(0, 99) >= sink_stall_pct);
	end

	always @(posedge clk) begin : monitor
		sfr_pkg::result_t want, seen;
		in_acc = arst_n && s_axis_tvalid && s_axis_tready;
		out_acc = arst_n && m_axis_tvalid && m_axis_tready;
		rx_taken = in_acc;
		if (in_acc) begin
			parse_results_q.push_back(parse_rx_item(sfr_pkg::req_type_t'(s_axis_tuser),
				s_axis_tdata));
			accepted_count++;
		end
		if (out_acc) begin
			if (parse_results_q.size() == 0) begin
				$display("%0t: unexpected result item, tuser 0x%0h tdata 0x%0h",
					$time, m_axis_tuser, m_axis_tdata);
				mismatch_count++;
			end else begin
				want = parse_results_q.pop_front();
				seen.status = sfr_pkg::status_t'(m_axis_tuser[2:0]);
				seen.payload_valid = m_axis_tuser[3];
				seen.payload_byte = m_axis_tdata[7:0];
				seen.payload_index = m_axis_tdata[17:8];
				seen.command_code = m_axis_tdata[25:18];
				seen.subcommand_code = m_axis_tdata[33:26];
				seen.payload_length = m_axis_tdata[49:34];
				seen.oversize = m_axis_tdata[50];
				check_field("status", 32'(want.status), 32'(seen.status));
				check_field("payload_valid", 32'(want.payload_valid), 32'(seen.payload_valid));
				check_field("payload_byte", 32'(want.payload_byte), 32'(seen.payload_byte));
				check_field("payload_index", 32'(want.payload_index), 32'(seen.payload_index));
				check_field("command_code", 32'(want.command_code), 32'(seen.command_code));
				check_field("subcommand_code", 32'(want.subcommand_code),
					32'(seen.subcommand_code));
				check_field("payload_length", 32'(want.payload_length),
					32'(seen.payload_length));
				check_field("oversize", 32'(want.oversize), 32'(seen.oversize));
			end
		end
		if (in_acc || out_acc)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : stimulus
		int          kind;
		logic [15:0] len;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// rearm while idle, noise while waiting, zero-length frame with a trailing
		// byte, bad checksum, oversize length aborted by rearm mid-payload
		add_item(sfr_pkg::REQ_REARM, 8'hFF);
		add_item(sfr_pkg::REQ_BYTE, 8'h00);
		add_frame(8'hFF, 8'h00, 16'd0, -1, 1'b0, 1);
		add_frame(8'h00, 8'hFF, 16'd1, -1, 1'b1, 0);
		add_frame(8'hA5, 8'h5A, 16'hFFFF, 6, 1'b0, 0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 84; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 84; end
				default: begin src_idle_pct = 18; sink_stall_pct = 18; end
			endcase
			phase_items = 0;
			while (phase_items < 110) begin
				if ($urandom_range(0, 9) == 0)
					add_item(sfr_pkg::REQ_REARM, 8'($urandom));
				repeat ($urandom_range(0, 1)) add_item(sfr_pkg::REQ_BYTE, 8'($urandom));
				kind = $urandom_range(0, 99);
				len = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
				if (kind < 10) begin
					len = ($urandom_range(0, 3) == 0) ? 16'd1024 :
						16'($urandom_range(1025, 65535));
					add_frame(8'($urandom), 8'($urandom), len, $urandom_range(5, 9), 1'b0, 0);
				end else if (kind < 22) begin
					add_frame(8'($urandom), 8'($urandom), len,
						$urandom_range(1, 6 + int'(len)), 1'b0, 0);
				end else begin
					add_frame(8'($urandom), 8'($urandom), len, -1, kind < 35,
						$urandom_range(0, 2));
				end
			end
			while (accepted_count != queued_count || parse_results_q.size() != 0)
				@(negedge clk);
		end

		repeat (4) @(negedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
